/* rtl/dlsq_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the sleep queue.
package dlsq_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = PTR_W + 1;
  localparam int unsigned PID_W    = 8;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned TL_W     = 10;
  localparam int unsigned TL_RESET = 10;
  localparam int unsigned ENTRY_W  = PID_W + DELTA_W;

  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    STAT_QUEUED = 2'd0,
    STAT_NOW    = 2'd1,
    STAT_TICK   = 2'd2,
    STAT_FULL   = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    RS_HEAD  = 2'd0,
    RS_HEAD1 = 2'd1,
    RS_POS   = 2'd2,
    RS_SHIFT = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    div_start;
    logic    rem_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    walk_step;
    logic    wr_shift;
    logic    wr_new;
    logic    wr_dec;
    logic    pop;
    logic    out_load;
    stat_e   out_stat;
    logic    out_last;
    logic    out_from_rd;
  } cmd_t;

  typedef struct packed {
    logic             is_tick;
    logic             ms_zero;
    logic             cnt_zero;
    logic             full;
    logic             div_done;
    logic             pos_lt_cnt;
    logic             rem_ge;
    logic             j_gt_pos;
    logic             d_le1;
    logic             d_zero;
    logic             cnt_gt1;
    logic [CNT_W-1:0] cnt;
  } stat_t;

endpackage

/* rtl/dlsq_div.sv */
// Restoring divider that turns a duration in ms into whole ticks, one quotient bit per cycle.
module dlsq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dlsq_pkg::MS_W-1:0]   dividend_i,
  input  logic [dlsq_pkg::TL_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [dlsq_pkg::MS_W-1:0]   quot_o,
  output logic                        rem_nz_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [$clog2(dlsq_pkg::MS_W)-1:0] cnt_q, cnt_d;
  logic [dlsq_pkg::MS_W-1:0]   q_q, q_d;
  logic [dlsq_pkg::TL_W-1:0]   r_q, r_d;
  logic [dlsq_pkg::TL_W-1:0]   dv_q, dv_d;
  logic [dlsq_pkg::TL_W:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    dv_d   = dv_q;
    trial  = {r_q, q_q[dlsq_pkg::MS_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      q_d    = dividend_i;
      r_d    = '0;
      dv_d   = (divisor_i == '0) ? dlsq_pkg::TL_W'(1) : divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        r_d = dlsq_pkg::TL_W'(trial - {1'b0, dv_q});
        q_d = {q_q[dlsq_pkg::MS_W-2:0], 1'b1};
      end else begin
        r_d = trial[dlsq_pkg::TL_W-1:0];
        q_d = {q_q[dlsq_pkg::MS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign done_o   = done_q;
  assign quot_o   = q_q;
  assign rem_nz_o = (r_q != '0);

endmodule

/* rtl/dlsq_dp.sv */
// Datapath: entry memory kept as a ring, walk and shift counters, tick divider and result register.
module dlsq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlsq_pkg::cmd_t                cmd_i,
  output dlsq_pkg::stat_t               stat_o,
  input  logic                          in_cmd_i,
  input  logic [dlsq_pkg::PID_W-1:0]    in_pid_i,
  input  logic [dlsq_pkg::MS_W-1:0]     in_ms_i,
  input  logic                          cfg_we_i,
  input  logic [dlsq_pkg::TL_W-1:0]     cfg_data_i,
  output dlsq_pkg::stat_e               out_stat_o,
  output logic [dlsq_pkg::PID_W-1:0]    out_pid_o,
  output logic                          out_last_o
);

  logic [dlsq_pkg::ENTRY_W-1:0] mem_q [dlsq_pkg::DEPTH];
  logic [dlsq_pkg::ENTRY_W-1:0] rdata_q;
  logic [dlsq_pkg::TL_W-1:0]    tl_q;
  logic [dlsq_pkg::PTR_W-1:0]   head_q;
  logic [dlsq_pkg::CNT_W-1:0]   cnt_q, pos_q, j_q;
  logic [dlsq_pkg::DELTA_W-1:0] rem_q;
  logic                         cmd_q;
  logic [dlsq_pkg::PID_W-1:0]   pend_q;
  logic [dlsq_pkg::MS_W-1:0]    ms_q;
  dlsq_pkg::stat_e              out_stat_q;
  logic [dlsq_pkg::PID_W-1:0]   out_pid_q;
  logic                         out_last_q;

  logic                         div_done;
  logic [dlsq_pkg::MS_W-1:0]    div_quot;
  logic                         div_rem_nz;

  logic [dlsq_pkg::PID_W-1:0]   rd_pid;
  logic [dlsq_pkg::DELTA_W-1:0] rd_delta;
  logic [dlsq_pkg::PTR_W-1:0]   rd_addr, wr_addr;
  logic [dlsq_pkg::ENTRY_W-1:0] wr_data;
  logic                         wr_en;
  logic [dlsq_pkg::CNT_W-1:0]   j_m1;
  logic [dlsq_pkg::DELTA_W-1:0] sh_delta;

  dlsq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(ms_q),
    .divisor_i (tl_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_nz_o  (div_rem_nz)
  );

  assign rd_pid   = rdata_q[dlsq_pkg::ENTRY_W-1:dlsq_pkg::DELTA_W];
  assign rd_delta = rdata_q[dlsq_pkg::DELTA_W-1:0];
  assign j_m1     = j_q - 1'b1;
  assign sh_delta = (j_m1 == pos_q) ? (rd_delta - rem_q) : rd_delta;

  always_comb begin
    case (cmd_i.rd_sel)
      dlsq_pkg::RS_HEAD:  rd_addr = head_q;
      dlsq_pkg::RS_HEAD1: rd_addr = head_q + 1'b1;
      dlsq_pkg::RS_POS:   rd_addr = head_q + pos_q[dlsq_pkg::PTR_W-1:0];
      dlsq_pkg::RS_SHIFT: rd_addr = head_q + j_m1[dlsq_pkg::PTR_W-1:0];
      default:            rd_addr = head_q;
    endcase
  end

  always_comb begin
    wr_en   = cmd_i.wr_shift | cmd_i.wr_new | cmd_i.wr_dec;
    wr_addr = head_q;
    wr_data = {rd_pid, rd_delta - 1'b1};
    if (cmd_i.wr_shift) begin
      wr_addr = head_q + j_q[dlsq_pkg::PTR_W-1:0];
      wr_data = {rd_pid, sh_delta};
    end else if (cmd_i.wr_new) begin
      wr_addr = head_q + pos_q[dlsq_pkg::PTR_W-1:0];
      wr_data = {pend_q, rem_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q   <= dlsq_pkg::TL_W'(dlsq_pkg::TL_RESET);
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        tl_q <= cfg_data_i;
      end
      if (cmd_i.pop) begin
        head_q <= head_q + 1'b1;
        cnt_q  <= cnt_q - 1'b1;
      end else if (cmd_i.wr_new) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= in_cmd_i;
      pend_q <= in_pid_i;
      ms_q   <= in_ms_i;
      pos_q  <= '0;
      j_q    <= cnt_q;
    end
    if (cmd_i.rem_load) begin
      rem_q <= div_quot + dlsq_pkg::DELTA_W'(div_rem_nz);
    end
    if (cmd_i.walk_step) begin
      rem_q <= rem_q - rd_delta;
      pos_q <= pos_q + 1'b1;
    end
    if (cmd_i.wr_shift) begin
      j_q <= j_m1;
    end
    if (cmd_i.pop) begin
      pend_q <= rd_pid;
    end
    if (cmd_i.out_load) begin
      out_stat_q <= cmd_i.out_stat;
      out_pid_q  <= cmd_i.out_from_rd ? rd_pid : pend_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  always_comb begin
    stat_o.is_tick    = (cmd_q == dlsq_pkg::CMD_TICK);
    stat_o.ms_zero    = (ms_q == '0);
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.full       = (cnt_q == dlsq_pkg::CNT_W'(dlsq_pkg::DEPTH));
    stat_o.div_done   = div_done;
    stat_o.pos_lt_cnt = (pos_q < cnt_q);
    stat_o.rem_ge     = (rem_q >= rd_delta);
    stat_o.j_gt_pos   = (j_q > pos_q);
    stat_o.d_le1      = (rd_delta <= dlsq_pkg::DELTA_W'(1));
    stat_o.d_zero     = (rd_delta == '0);
    stat_o.cnt_gt1    = (cnt_q > dlsq_pkg::CNT_W'(1));
    stat_o.cnt        = cnt_q;
  end

  assign out_stat_o = out_stat_q;
  assign out_pid_o  = out_pid_q;
  assign out_last_o = out_last_q;

endmodule

/* rtl/dlsq_ctrl.sv */
// Controller state machine sequencing requests, ticks and result handoff.
module dlsq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dlsq_pkg::stat_t  stat_i,
  output dlsq_pkg::cmd_t   cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_REQ  = 12'b000000000010,
    S_DIV  = 12'b000000000100,
    S_WRD  = 12'b000000001000,
    S_WCMP = 12'b000000010000,
    S_SRD  = 12'b000000100000,
    S_SWR  = 12'b000001000000,
    S_INS  = 12'b000010000000,
    S_TDEC = 12'b000100000000,
    S_WPOP = 12'b001000000000,
    S_WCHK = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   more_q, more_d;

  always_comb begin
    state_d = state_q;
    more_d  = more_q;
    cmd_o   = '0;
    cmd_o.rd_sel   = dlsq_pkg::RS_HEAD;
    cmd_o.out_stat = dlsq_pkg::STAT_QUEUED;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_REQ;
        end
      end
      S_REQ: begin
        more_d = 1'b0;
        if (stat_i.is_tick) begin
          if (stat_i.cnt_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d = S_TDEC;
          end
        end else if (stat_i.ms_zero || stat_i.full) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_stat = stat_i.ms_zero ? dlsq_pkg::STAT_NOW : dlsq_pkg::STAT_FULL;
          cmd_o.out_last = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.rem_load = 1'b1;
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        if (stat_i.pos_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = dlsq_pkg::RS_POS;
          state_d = S_WCMP;
        end else begin
          state_d = S_SRD;
        end
      end
      S_WCMP: begin
        if (stat_i.rem_ge) begin
          cmd_o.walk_step = 1'b1;
          state_d = S_WRD;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (stat_i.j_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = dlsq_pkg::RS_SHIFT;
          state_d = S_SWR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SWR: begin
        cmd_o.wr_shift = 1'b1;
        state_d = S_SRD;
      end
      S_INS: begin
        cmd_o.wr_new   = 1'b1;
        cmd_o.out_load = 1'b1;
        cmd_o.out_stat = dlsq_pkg::STAT_QUEUED;
        cmd_o.out_last = 1'b1;
        state_d = S_OUT;
      end
      S_TDEC: begin
        if (stat_i.d_le1) begin
          state_d = S_WPOP;
        end else begin
          cmd_o.wr_dec = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WPOP: begin
        cmd_o.pop = 1'b1;
        if (stat_i.cnt_gt1) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = dlsq_pkg::RS_HEAD1;
          state_d = S_WCHK;
        end else begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_stat    = dlsq_pkg::STAT_TICK;
          cmd_o.out_last    = 1'b1;
          cmd_o.out_from_rd = 1'b1;
          more_d  = 1'b0;
          state_d = S_OUT;
        end
      end
      S_WCHK: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_stat = dlsq_pkg::STAT_TICK;
        cmd_o.out_last = !stat_i.d_zero;
        more_d  = stat_i.d_zero;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = more_q ? S_WPOP : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

/* rtl/delta_list_sleep_queue_core.sv */
// Top level of the delta-list sleep timer queue.
//
// Input stream: one transaction per sleep request or timer tick. tuser selects
// the kind (0 sleep, 1 tick); tdata carries the process id and the duration in ms.
// Output stream: one transaction per result; tuser is the status, tdata the
// process id, tlast marks the final result caused by an input.
// Config channel: writes the tick length in ms (0 acts as 1); always ready.
// One input is handled at a time; s_axis_tready is high only when idle.
// A zero-duration or rejected request is answered without the divider. A queued
// request passes through the tick divider, then each held entry is either
// walked or shifted in the entry memory before the new entry is written. A
// tick decrements the head delta or wakes the due processes one by one.
// Reset empties the queue and sets the tick length to 10 ms; no clearing pass.
// When the receiver stalls, the pending result holds in the output register
// and the block takes no new input until it is delivered.
module delta_list_sleep_queue_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // process_id, duration_ms
  input  logic                       s_axis_tuser,  // command
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // woken_process
  output logic [1:0]                 m_axis_tuser,  // status
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dlsq_pkg::TL_W-1:0]  cfg_data_i
);

  dlsq_pkg::cmd_t  cmd;
  dlsq_pkg::stat_t stat;
  dlsq_pkg::stat_e out_stat;

  assign cfg_ready_o = 1'b1;

  dlsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dlsq_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_cmd_i  (s_axis_tuser),
    .in_pid_i  (s_axis_tdata[7:0]),
    .in_ms_i   (s_axis_tdata[39:8]),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .out_stat_o(out_stat),
    .out_pid_o (m_axis_tdata),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tuser = out_stat;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt <= dlsq_pkg::CNT_W'(dlsq_pkg::DEPTH))
    else $error("entry count exceeds queue depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_req_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != dlsq_pkg::STAT_TICK) |-> m_axis_tlast)
    else $error("request result without last");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !stat.cnt_zero)
    else $error("pop on empty queue");
`endif

endmodule
